FILE: design/cce_pkg.sv
// Shared types and constants of the control character escape codec.
// No dependencies; every other design file but cce_if.sv imports this package.
package cce_pkg;

	// Character codes
	localparam logic [7:0] ESC_CHAR   = 8'h25;	// '%'
	localparam logic [7:0] ESC_OFFSET = 8'h40;	// '@'
	localparam logic [7:0] CTRL_LIMIT = 8'h20;	// ' '
	localparam logic [7:0] DEC_LOW    = 8'h41;
	localparam logic [7:0] DEC_HIGH   = 8'h5F;	// '_'

	// Closing status codes
	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	// Configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_MODE  = 1'd0;
	localparam cfg_idx_t REG_EXTRA = 1'd1;

	// Codec modes
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	// Results of one item, apart from the error position
	typedef struct packed {
		logic [1:0] nbytes;	// produced bytes, 0..2
		logic [7:0] b0;
		logic [7:0] b1;
		logic       close;	// closing beat follows the bytes
		logic [1:0] close_status;
	} byte_res_t;

endpackage

FILE: design/cce_if.sv
// Stream channels of the control character escape codec.
// Input items and result items, each with valid/ready handshake.
interface cce_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_string;

	modport source (output valid, data_byte, byte_present, end_of_string, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_string, output ready);
endinterface

interface cce_out_if #(parameter int PW = 16);
	logic          valid;
	logic          ready;
	logic [7:0]    out_byte;
	logic          out_valid;
	logic [1:0]    status;
	logic [PW-1:0] error_position;
	logic          last;

	modport source (output valid, out_byte, out_valid, status, error_position, last,
		input ready);
	modport sink (input valid, out_byte, out_valid, status, error_position, last,
		output ready);
endinterface

FILE: design/cce_step.sv
// Per-item escape/unescape logic and next string state, purely combinational.
// Depends on cce_pkg.
module cce_step #(
	parameter int PW = 16
) (
	input  logic                mode,
	input  logic [7:0]          extra,
	input  logic [7:0]          data_byte,
	input  logic                byte_present,
	input  logic                end_of_string,
	input  logic                pend,
	input  logic                err,
	input  logic [PW-1:0]       pos,
	input  logic [PW-1:0]       saved,
	output logic                pend_n,
	output logic                err_n,
	output logic [PW-1:0]       pos_n,
	output logic [PW-1:0]       saved_n,
	output cce_pkg::byte_res_t  res,
	output logic [PW-1:0]       close_epos
);
	import cce_pkg::*;

	logic          take;
	logic [PW-1:0] pos_a;
	logic [PW-1:0] pos_a_inc;
	logic          pend_a;
	logic          err_a;
	logic [PW-1:0] saved_a;
	logic          err_b;
	logic [PW-1:0] saved_b;
	logic          extra_on;
	logic          enc_ctrl;
	logic          dec_ok;

	assign take      = byte_present && !err;
	assign pos_a     = (take && pos != '1) ? pos + 1'b1 : pos;
	assign pos_a_inc = (pos_a != '1) ? pos_a + 1'b1 : pos_a;
	assign extra_on  = (extra != 8'd0);
	assign enc_ctrl  = (data_byte < CTRL_LIMIT) || (extra_on && data_byte == extra);
	assign dec_ok    = (data_byte inside {[DEC_LOW:DEC_HIGH]})
		|| (extra_on && data_byte == extra + ESC_OFFSET);

	// Translate the byte and flag errors
	always_comb begin
		res.nbytes = 2'd0;
		res.b0     = data_byte;
		res.b1     = ESC_CHAR;
		pend_a     = pend;
		err_a      = err;
		saved_a    = saved;
		if (take) begin
			if (mode == MODE_ENC) begin
				if (enc_ctrl) begin
					res.nbytes = 2'd2;
					res.b0     = ESC_CHAR;
					res.b1     = data_byte + ESC_OFFSET;
				end else if (data_byte == ESC_CHAR) begin
					res.nbytes = 2'd2;
					res.b0     = ESC_CHAR;
				end else begin
					res.nbytes = 2'd1;
				end
			end else if (pend) begin
				pend_a = 1'b0;
				if (dec_ok) begin
					res.nbytes = 2'd1;
					res.b0     = data_byte - ESC_OFFSET;
				end else if (data_byte == ESC_CHAR) begin
					res.nbytes = 2'd1;
				end else begin
					err_a   = 1'b1;
					saved_a = pos_a;
				end
			end else if (data_byte < CTRL_LIMIT) begin
				err_a   = 1'b1;
				saved_a = pos_a;
			end else if (data_byte == ESC_CHAR) begin
				pend_a = 1'b1;
			end else begin
				res.nbytes = 2'd1;
			end
		end
	end

	// Close the string: trailing percent check, status, state clear
	always_comb begin
		err_b   = err_a;
		saved_b = saved_a;
		if (!err_a && mode == MODE_DEC && pend_a) begin
			err_b   = 1'b1;
			saved_b = pos_a_inc;
		end
	end

	assign res.close        = end_of_string;
	assign res.close_status = err_b ? ST_ERR : ST_OK;
	assign close_epos       = err_b ? saved_b : '0;

	assign pend_n  = end_of_string ? 1'b0 : pend_a;
	assign err_n   = end_of_string ? 1'b0 : err_a;
	assign pos_n   = end_of_string ? '0 : pos_a;
	assign saved_n = end_of_string ? '0 : saved_a;

endmodule

FILE: design/control_char_escape_codec.sv
// Control character escape codec, top level.
// Depends on cce_pkg, cce_in_if, cce_out_if and cce_step.
//
//  channel   | role  | beat content
//  ----------+-------+------------------------------------------------------------
//  item_in   | sink  | data_byte, byte_present, end_of_string
//  res_out   | source| out_byte, out_valid, status, error_position, last
//  cfg_*     | write | cfg_we, cfg_index (0 codec_mode, 1 extra_escape), cfg_wdata
//
// An item is translated in the cycle it is accepted and its results (0 to 3 beats)
// are held in a small result buffer that feeds the output register one beat a cycle
// unless the output stalls. An item with at most one result is taken every cycle
// unless the output stalls; an item with more results holds the input until its last
// beat is loaded. Results pass from the result buffer to the output register.
// arst_n clears the string state, the configuration and both buffer valids.
// A stalled output holds its beat; the input is taken again once the buffer drains.
module control_char_escape_codec #(
	parameter int POSITION_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	cce_in_if.sink            item_in,
	cce_out_if.source         res_out,
	input  logic              cfg_we,
	input  cce_pkg::cfg_idx_t cfg_index,
	input  logic [7:0]        cfg_wdata
);
	import cce_pkg::*;

	localparam int PW = POSITION_WIDTH;

	// Configuration and string state
	logic          mode_q;
	logic [7:0]    extra_q;
	logic          pend_q;
	logic          err_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] saved_q;

	logic          pend_n;
	logic          err_n;
	logic [PW-1:0] pos_n;
	logic [PW-1:0] saved_n;
	byte_res_t     res;
	logic [PW-1:0] close_epos;

	// Result buffer
	logic [1:0]    nb_q;
	logic          close_q;
	logic [7:0]    b0_q;
	logic [7:0]    b1_q;
	logic [1:0]    cst_q;
	logic [PW-1:0] cep_q;

	// Output register
	logic          ov_q;
	logic [7:0]    ob_q;
	logic          obv_q;
	logic [1:0]    ost_q;
	logic [PW-1:0] oep_q;
	logic          olast_q;

	logic buf_empty;
	logic buf_one;
	logic load;
	logic in_fire;

	cce_step #(.PW(PW)) u_step (
		.mode          (mode_q),
		.extra         (extra_q),
		.data_byte     (item_in.data_byte),
		.byte_present  (item_in.byte_present),
		.end_of_string (item_in.end_of_string),
		.pend          (pend_q),
		.err           (err_q),
		.pos           (pos_q),
		.saved         (saved_q),
		.pend_n        (pend_n),
		.err_n         (err_n),
		.pos_n         (pos_n),
		.saved_n       (saved_n),
		.res           (res),
		.close_epos    (close_epos)
	);

	assign buf_empty    = (nb_q == 2'd0) && !close_q;
	assign buf_one      = ((nb_q == 2'd1) && !close_q) || ((nb_q == 2'd0) && close_q);
	assign load         = !buf_empty && (!ov_q || res_out.ready);
	assign item_in.ready = buf_empty || (buf_one && load);
	assign in_fire      = item_in.valid && item_in.ready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ENC;
			extra_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  mode_q  <= cfg_wdata[0];
				REG_EXTRA: extra_q <= cfg_wdata;
				default:   mode_q  <= mode_q;
			endcase
		end
	end

	// Advance string state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			err_q   <= 1'b0;
			pos_q   <= '0;
			saved_q <= '0;
		end else if (in_fire) begin
			pend_q  <= pend_n;
			err_q   <= err_n;
			pos_q   <= pos_n;
			saved_q <= saved_n;
		end
	end

	// Fill the result buffer, or drain its head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q    <= 2'd0;
			close_q <= 1'b0;
		end else if (in_fire) begin
			nb_q    <= res.nbytes;
			close_q <= res.close;
		end else if (load) begin
			if (nb_q != 2'd0) begin
				nb_q <= nb_q - 2'd1;
			end else begin
				close_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			b0_q  <= res.b0;
			b1_q  <= res.b1;
			cst_q <= res.close_status;
			cep_q <= close_epos;
		end else if (load && nb_q != 2'd0) begin
			b0_q <= b1_q;
		end
	end

	// Load the output register from the buffer head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load) begin
			ov_q <= 1'b1;
		end else if (res_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (nb_q != 2'd0) begin
				ob_q    <= b0_q;
				obv_q   <= 1'b1;
				ost_q   <= ST_BUSY;
				oep_q   <= '0;
				olast_q <= 1'b0;
			end else begin
				ob_q    <= 8'd0;
				obv_q   <= 1'b0;
				ost_q   <= cst_q;
				oep_q   <= cep_q;
				olast_q <= 1'b1;
			end
		end
	end

	assign res_out.valid          = ov_q;
	assign res_out.out_byte       = ob_q;
	assign res_out.out_valid      = obv_q;
	assign res_out.status         = ost_q;
	assign res_out.error_position = oep_q;
	assign res_out.last           = olast_q;

endmodule

FILE: design/cce_checker.sv
// Port-level checks of the control character escape codec, bound to the top level.
// Depends on cce_pkg.
module cce_checker #(
	parameter int PW = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          o_valid,
	input logic          o_ready,
	input logic [7:0]    o_byte,
	input logic          o_byte_valid,
	input logic [1:0]    o_status,
	input logic [PW-1:0] o_epos,
	input logic          o_last
);
	import cce_pkg::*;

	// Closing beat carries no byte and a final status
	a_close_form: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_last |-> !o_byte_valid && (o_status == ST_OK || o_status == ST_ERR))
		else $error("closing beat malformed");

	// Byte beats are in progress with no error position
	a_byte_form: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_last |-> o_byte_valid && o_status == ST_BUSY && o_epos == '0)
		else $error("byte beat malformed");

	// Error position is set exactly on error closes
	a_epos: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_last |-> ((o_status == ST_ERR) == (o_epos != '0)))
		else $error("error position disagrees with status");

	// Stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid && $stable(o_byte) && $stable(o_last))
		else $error("stalled beat changed");

endmodule

bind control_char_escape_codec cce_checker #(.PW(POSITION_WIDTH)) u_cce_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.o_valid      (res_out.valid),
	.o_ready      (res_out.ready),
	.o_byte       (res_out.out_byte),
	.o_byte_valid (res_out.out_valid),
	.o_status     (res_out.status),
	.o_epos       (res_out.error_position),
	.o_last       (res_out.last)
);

FILE: verif/control_char_escape_codec_test.sv
// Testbench of control_char_escape_codec: directed table, random strings per setting, long string.
// Every result beat is checked against the table where it gives results, else the in-bench predictor.
// Depends on cce_pkg, cce_in_if, cce_out_if and the control_char_escape_codec RTL.
`timescale 1ns / 1ps

module control_char_escape_codec_test;
	import cce_pkg::*;

	localparam int PW = 16;
	localparam int RAND_ITEMS = 400;
	localparam int N_PHASES = 9;
	localparam int LONG_LEN = 24;

	// One result beat, field by field
	typedef struct packed {
		logic [7:0]    out_byte;
		logic          out_valid;
		logic [1:0]    status;
		logic [PW-1:0] error_position;
		logic          last;
	} res_beat_t;

	// Results written into the table; n of zero leaves them to the predictor
	typedef struct packed {
		logic [1:0]      n;
		res_beat_t [2:0] beats;
	} known_res_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e  kind;
		logic [7:0] data;
		logic       present;
		logic       eos;
		logic       mode;
		logic [7:0] extra;
		known_res_t known;
	} stim_row_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] extra;
	} codec_cfg_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [7:0] cfg_wdata;

	cce_in_if item_bus();
	cce_out_if #(.PW(PW)) res_bus();

	// Table expectation that travels with the item beat
	known_res_t known_tag;

	// Predictor state and configuration copy
	logic pred_mode = MODE_ENC;
	logic [7:0] pred_extra = 8'h00;
	logic pct_wait = 1'b0;
	logic str_err = 1'b0;
	logic [PW-1:0] str_pos = '0;
	logic [PW-1:0] str_err_pos = '0;
	res_beat_t codec_beats_q[$];

	// Sender-side copy of the setting, used to shape the strings
	logic cur_mode = MODE_ENC;
	logic [7:0] cur_extra = 8'h00;

	int fail_count = 0;
	int items_sent = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit long_hold_req = 1'b0;
	int unsigned stall_left = 0;

	control_char_escape_codec u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (item_bus),
		.res_out  (res_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic res_beat_t db(input logic [7:0] b);
		return res_beat_t'{b, 1'b1, ST_BUSY, {PW{1'b0}}, 1'b0};
	endfunction

	function automatic res_beat_t close_res(input logic [1:0] st, input logic [PW-1:0] pos);
		return res_beat_t'{8'h00, 1'b0, st, pos, 1'b1};
	endfunction

	function automatic known_res_t known_res(input logic [1:0] n, input res_beat_t b0 = '0,
			input res_beat_t b1 = '0, input res_beat_t b2 = '0);
		known_res_t k;
		k.n = n;
		k.beats[0] = b0;
		k.beats[1] = b1;
		k.beats[2] = b2;
		return k;
	endfunction

	function automatic stim_row_t dir_item(input logic [7:0] d, input logic p, input logic e,
			input known_res_t k = '0);
		return stim_row_t'{ROW_ITEM, d, p, e, 1'b0, 8'h00, k};
	endfunction

	function automatic stim_row_t dir_cfg(input logic m, input logic [7:0] x);
		return stim_row_t'{ROW_CFG, 8'h00, 1'b0, 1'b0, m, x, known_res_t'(0)};
	endfunction

	function automatic logic [PW-1:0] pos_next(input logic [PW-1:0] p);
		return (p == {PW{1'b1}}) ? p : p + 1'b1;
	endfunction

	// Escape or unescape one item and advance the string state
	function automatic void codec_predict(input logic [7:0] c, input logic present,
			input logic eos, output int n, output res_beat_t [2:0] beats);
		logic [7:0] partner;
		n = 0;
		beats = '0;
		partner = pred_extra + ESC_OFFSET;
		if (present && !str_err) begin
			str_pos = pos_next(str_pos);
			if (pred_mode == MODE_ENC) begin
				if (c < CTRL_LIMIT || (pred_extra != 8'h00 && c == pred_extra)) begin
					beats[n] = db(ESC_CHAR);
					n++;
					beats[n] = db(c + ESC_OFFSET);
					n++;
				end else if (c == ESC_CHAR) begin
					beats[n] = db(ESC_CHAR);
					n++;
					beats[n] = db(ESC_CHAR);
					n++;
				end else begin
					beats[n] = db(c);
					n++;
				end
			end else if (pct_wait) begin
				pct_wait = 1'b0;
				if ((c >= DEC_LOW && c <= DEC_HIGH) || (pred_extra != 8'h00 && c == partner)) begin
					beats[n] = db(c - ESC_OFFSET);
					n++;
				end else if (c == ESC_CHAR) begin
					beats[n] = db(ESC_CHAR);
					n++;
				end else begin
					str_err = 1'b1;
					str_err_pos = str_pos;
				end
			end else if (c < CTRL_LIMIT) begin
				str_err = 1'b1;
				str_err_pos = str_pos;
			end else if (c == ESC_CHAR) begin
				pct_wait = 1'b1;
			end else begin
				beats[n] = db(c);
				n++;
			end
		end
		if (eos) begin
			// a dangling percent at the end counts as one byte past the string
			if (!str_err && pred_mode == MODE_DEC && pct_wait) begin
				str_err = 1'b1;
				str_err_pos = pos_next(str_pos);
			end
			beats[n] = str_err ? close_res(ST_ERR, str_err_pos) : close_res(ST_OK, '0);
			n++;
			pct_wait = 1'b0;
			str_err = 1'b0;
			str_pos = '0;
			str_err_pos = '0;
		end
	endfunction

	task automatic report(input string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_beat(input res_beat_t got);
		res_beat_t want;
		if (codec_beats_q.size() == 0) begin
			report($sformatf("result beat %h with nothing expected", got));
		end else begin
			want = codec_beats_q.pop_front();
			if (got.out_byte !== want.out_byte)
				report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
			if (got.out_valid !== want.out_valid)
				report($sformatf("out_valid %b, expected %b", got.out_valid, want.out_valid));
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.error_position !== want.error_position)
				report($sformatf("error_position %0d, expected %0d",
					got.error_position, want.error_position));
			if (got.last !== want.last)
				report($sformatf("last %b, expected %b", got.last, want.last));
		end
	endtask

	// Track register writes, check result beats, predict accepted items
	always @(posedge clk) begin
		int n;
		res_beat_t [2:0] beats;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: pred_mode = cfg_wdata[0];
					REG_EXTRA: pred_extra = cfg_wdata;
					default: ;
				endcase
			end
			if (res_bus.valid && res_bus.ready)
				check_beat(res_beat_t'{res_bus.out_byte, res_bus.out_valid, res_bus.status,
					res_bus.error_position, res_bus.last});
			if (item_bus.valid && item_bus.ready) begin
				codec_predict(item_bus.data_byte, item_bus.byte_present,
					item_bus.end_of_string, n, beats);
				if (known_tag.n != 2'd0) begin
					n = known_tag.n;
					beats = known_tag.beats;
				end
				for (int k = 0; k < n; k++)
					codec_beats_q.push_back(beats[k]);
			end
		end
	end

	// Result side: random stall bursts, one long hold on request
	initial begin
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(0, 12);
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	// Offer one item beat and hold it until taken
	task automatic send_item(input logic [7:0] d, input logic p, input logic e,
			input known_res_t k);
		item_bus.valid <= 1'b1;
		item_bus.data_byte <= d;
		item_bus.byte_present <= p;
		item_bus.end_of_string <= e;
		known_tag <= k;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		if (p || e)
			items_sent++;
	endtask

	task automatic maybe_gap();
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Drop valid, wait out every pending result, then let the pipeline empty
	task automatic settle();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (codec_beats_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_codec(input logic m, input logic [7:0] x);
		cfg_we <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_wdata <= {7'b0, m};
		@(posedge clk);
		cfg_index <= REG_EXTRA;
		cfg_wdata <= x;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_mode = m;
		cur_extra = x;
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b < CTRL_LIMIT || b == ESC_CHAR);
		return b;
	endfunction

	// Build one string for the current setting and send it; {present, byte} per entry
	task automatic send_rand_string();
		logic [8:0] str_q[$];
		int len;
		int r;
		bit end_on_last;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 8);
		while (str_q.size() < len) begin
			r = $urandom_range(0, 99);
			if (cur_mode == MODE_DEC) begin
				if (r < 55) begin
					str_q.push_back({1'b1, plain_byte()});
				end else if (r < 73) begin
					str_q.push_back({1'b1, ESC_CHAR});
					str_q.push_back({1'b1, 8'($urandom_range(DEC_LOW, DEC_HIGH))});
				end else if (r < 80) begin
					str_q.push_back({1'b1, ESC_CHAR});
					str_q.push_back({1'b1, ESC_CHAR});
				end else if (r < 86) begin
					str_q.push_back({1'b1, ESC_CHAR});
					str_q.push_back({1'b1, cur_extra + ESC_OFFSET});
				end else if (r < 91) begin
					str_q.push_back({1'b1, 8'($urandom_range(0, 31))});
				end else if (r < 95) begin
					str_q.push_back({1'b1, ESC_CHAR});
					str_q.push_back({1'b1, 8'($urandom)});
				end else begin
					str_q.push_back({1'b0, 8'($urandom)});
				end
			end else begin
				if (r < 45)
					str_q.push_back({1'b1, 8'($urandom)});
				else if (r < 65)
					str_q.push_back({1'b1, 8'($urandom_range(0, 31))});
				else if (r < 77)
					str_q.push_back({1'b1, ESC_CHAR});
				else if (r < 87)
					str_q.push_back({1'b1, cur_extra});
				else if (r < 95)
					str_q.push_back({1'b1, plain_byte()});
				else
					str_q.push_back({1'b0, 8'($urandom)});
			end
		end
		if (cur_mode == MODE_DEC && $urandom_range(0, 9) == 0)
			str_q.push_back({1'b1, ESC_CHAR});
		end_on_last = str_q.size() != 0 && str_q[$][8] && $urandom_range(0, 1) == 1;
		foreach (str_q[i]) begin
			maybe_gap();
			send_item(str_q[i][7:0], str_q[i][8], end_on_last && i == str_q.size() - 1, '0);
		end
		if (!end_on_last) begin
			maybe_gap();
			send_item(8'($urandom), 1'b0, 1'b1, '0);
		end
	endtask

	initial begin
		stim_row_t dir_rows[$];
		codec_cfg_t phases[N_PHASES];
		int goal;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_wdata <= 8'h00;
		item_bus.valid <= 1'b0;
		item_bus.data_byte <= 8'h00;
		item_bus.byte_present <= 1'b0;
		item_bus.end_of_string <= 1'b0;
		known_tag <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset setting is encode with no extra byte
		dir_rows = '{
			// zero byte and top control byte
			dir_item(8'h00, 1'b1, 1'b0, known_res(2'd2, db(ESC_CHAR), db(8'h40))),
			dir_item(8'h1F, 1'b1, 1'b0, known_res(2'd2, db(ESC_CHAR), db(8'h5F))),
			dir_item(ESC_CHAR, 1'b1, 1'b0, known_res(2'd2, db(ESC_CHAR), db(ESC_CHAR))),
			dir_item(8'hFF, 1'b1, 1'b0, known_res(2'd1, db(8'hFF))),
			dir_item(8'h41, 1'b1, 1'b0),
			// empty item gives nothing
			dir_item(8'h00, 1'b0, 1'b0),
			dir_item(8'h20, 1'b1, 1'b1, known_res(2'd2, db(8'h20), close_res(ST_OK, '0))),
			// empty end item
			dir_item(8'h00, 1'b0, 1'b1, known_res(2'd1, close_res(ST_OK, '0))),
			dir_cfg(MODE_ENC, 8'h7E),
			dir_item(8'h7E, 1'b1, 1'b0, known_res(2'd2, db(ESC_CHAR), db(8'hBE))),
			dir_item(8'hA5, 1'b1, 1'b1),
			dir_cfg(MODE_DEC, 8'hFF),
			dir_item(ESC_CHAR, 1'b1, 1'b0),
			dir_item(8'h3F, 1'b1, 1'b0, known_res(2'd1, db(8'hFF))),
			dir_item(ESC_CHAR, 1'b1, 1'b0),
			dir_item(ESC_CHAR, 1'b1, 1'b0, known_res(2'd1, db(ESC_CHAR))),
			dir_item(ESC_CHAR, 1'b1, 1'b0),
			dir_item(DEC_LOW, 1'b1, 1'b0, known_res(2'd1, db(8'h01))),
			dir_item(ESC_CHAR, 1'b1, 1'b0),
			dir_item(DEC_HIGH, 1'b1, 1'b0, known_res(2'd1, db(8'h1F))),
			dir_item(8'h80, 1'b1, 1'b1),
			// raw control byte, then a byte that must be dropped
			dir_item(8'h00, 1'b1, 1'b0),
			dir_item(8'h41, 1'b1, 1'b1, known_res(2'd1, close_res(ST_ERR, 16'd1))),
			// trailing percent
			dir_item(ESC_CHAR, 1'b1, 1'b0),
			dir_item(8'h00, 1'b0, 1'b1, known_res(2'd1, close_res(ST_ERR, 16'd2))),
			// bad byte after percent
			dir_item(ESC_CHAR, 1'b1, 1'b0),
			dir_item(8'h60, 1'b1, 1'b1, known_res(2'd1, close_res(ST_ERR, 16'd2))),
			// switch to encode with a percent still pending
			dir_item(ESC_CHAR, 1'b1, 1'b0),
			dir_cfg(MODE_ENC, 8'h00),
			dir_item(8'h41, 1'b1, 1'b1, known_res(2'd2, db(8'h41), close_res(ST_OK, '0)))
		};
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				settle();
				set_codec(dir_rows[i].mode, dir_rows[i].extra);
			end else begin
				maybe_gap();
				send_item(dir_rows[i].data, dir_rows[i].present, dir_rows[i].eos,
					dir_rows[i].known);
			end
		end

		// Random strings over a spread of settings, extremes included
		phases[0] = '{MODE_ENC, 8'h00};
		phases[1] = '{MODE_DEC, 8'h00};
		phases[2] = '{MODE_ENC, 8'hFF};
		phases[3] = '{MODE_DEC, 8'hFF};
		phases[4] = '{MODE_DEC, 8'h01};
		phases[5] = '{MODE_ENC, ESC_CHAR};
		phases[6] = '{MODE_DEC, 8'hE5};
		phases[7] = '{MODE_ENC, 8'($urandom)};
		phases[8] = '{MODE_DEC, 8'($urandom)};
		items_sent = 0;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			set_codec(phases[ph].mode, phases[ph].extra);
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			// hold the result side off while items keep coming
			if (ph == 2)
				long_hold_req = 1'b1;
			goal = (ph + 1) * RAND_ITEMS / N_PHASES;
			while (items_sent < goal)
				send_rand_string();
		end

		// No idling from here on; a plain decode string ended by a raw control byte, then encode strings
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		settle();
		set_codec(MODE_DEC, 8'h00);
		for (int i = 0; i < LONG_LEN; i++)
			send_item(8'($urandom_range(8'h26, 8'hFF)), 1'b1, 1'b0, '0);
		send_item(8'h00, 1'b1, 1'b1, known_res(2'd1, close_res(ST_ERR, PW'(LONG_LEN + 1))));
		settle();
		set_codec(MODE_ENC, 8'hFF);
		repeat (4) send_rand_string();

		settle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("control_char_escape_codec_test: clean");
		else
			$display("control_char_escape_codec_test: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("control_char_escape_codec_test: errors");
		$finish;
	end

endmodule
